// ===== hw/rtl/fbha_pkg.sv =====
// Shared types, constants and state codes for the fixed block heap allocator.
package fbha_pkg;

    localparam int HEAP_BYTES_DEF  = 2048;
    localparam int BLOCK_BYTES_DEF = 8;
    localparam int BLOCK_COUNT_DEF = HEAP_BYTES_DEF / (BLOCK_BYTES_DEF + 1);

    localparam int OP_W      = 1;
    localparam int BYTES_W   = 11;
    localparam int ADDR_W    = 11;
    localparam int STATUS_W  = 2;
    localparam int BLKNUM_W  = 8;
    localparam int MAP_W     = 8;

    // Shift used for the reciprocal multiply that turns a heap offset into a
    // block number. With offsets below 2^11 and blocks of at most 64 bytes,
    // a 20-bit shift gives the exact quotient.
    localparam int RECIP_SHIFT = 20;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  release_address;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted_address;
        logic [BLKNUM_W-1:0] block_number;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FREE,
        S_RESP
    } state_t;

endpackage

// ===== hw/rtl/fbha_block_map.sv =====
// Block map memory with one registered read port, one write port and a clear sweep after reset.
module fbha_block_map
    import fbha_pkg::*;
#(
    parameter int  DEPTH = BLOCK_COUNT_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [MAP_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [MAP_W-1:0] wr_data,
    output logic             busy
);

    logic [MAP_W-1:0] mem [DEPTH];

    logic [MAP_W-1:0] rd_data_reg;
    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    clr_next;
    logic             busy_reg;
    logic             busy_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MAP_W-1:0] mem_wdata;

    // The sweep owns the write port until every entry holds zero.
    always_comb
    begin
        mem_we    = wr_en;
        mem_waddr = wr_addr;
        mem_wdata = wr_data;
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
            clr_next  = clr_reg + AW'(1);
            if (clr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== hw/rtl/fixed_block_heap_allocator.sv =====
// Top level of the first-fit allocator over a heap of fixed-size blocks.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and results
// leave on the rsp channel (rsp_valid, rsp_stall, rsp); one result per item.
// An allocate item scans the block map from block zero, one map entry per
// cycle, skipping over allocated runs by their stored length, and stops at the
// first free run that covers the request. A free item clears the map entry of
// the block that holds the given address.
// The time from accept to rsp_valid of an allocate grows with the number of
// map entries the scan visits. The map memory's single read port, fed back
// through the skip adder, sets the one-entry-per-cycle scan pace.
// One item is in work at a time; req_stall is high while an item is in work.
// The result register lets a new item be accepted while the previous result
// still waits on a stalled receiver; a finished result then waits until the
// output register frees up.
// After reset the map is swept to zero, one entry per cycle, and req_stall
// stays high during the sweep.
module fixed_block_heap_allocator
    import fbha_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // The map sits at the bottom of the heap, so the data blocks start at the
    // byte address equal to the block count.
    localparam int BLOCK_COUNT  = HEAP_BYTES / (BLOCK_BYTES + 1);
    localparam int BLK_W        = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    // The scan position can jump past the end by up to one full map entry.
    localparam int CUR_W        = $clog2(BLOCK_COUNT + (1 << MAP_W));
    localparam int FOUND_W      = BYTES_W;
    localparam int FB_W         = BYTES_W + 1;
    localparam int RECIP_M      = ((1 << RECIP_SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int PROD_W       = 32;

    state_t              state_reg;
    state_t              state_next;
    logic [CUR_W-1:0]    cur_reg;
    logic [CUR_W-1:0]    cur_next;
    logic [BLK_W-1:0]    start_reg;
    logic [BLK_W-1:0]    start_next;
    logic [FOUND_W-1:0]  found_reg;
    logic [FOUND_W-1:0]  found_next;
    logic [FB_W-1:0]     fb_reg;
    logic [FB_W-1:0]     fb_next;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  bytes_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    rsp_t                res_reg;
    rsp_t                res_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    logic                map_rd_en;
    logic [BLK_W-1:0]    map_rd_addr;
    logic [MAP_W-1:0]    map_rd_data;
    logic                map_wr_en;
    logic [BLK_W-1:0]    map_wr_addr;
    logic [MAP_W-1:0]    map_wr_data;
    logic                map_busy;

    logic                req_accept;
    logic                rsp_free;
    logic [CUR_W-1:0]    cur_inc;
    logic [CUR_W-1:0]    cur_skip;
    logic [FB_W-1:0]     fb_inc;
    logic [FOUND_W-1:0]  found_inc;
    logic [ADDR_W-1:0]   free_offset;
    logic                free_below_heap;
    logic [ADDR_W-1:0]   free_quot;
    logic [PROD_W-1:0]   grant_full;

    fbha_block_map #(
        .DEPTH (BLOCK_COUNT)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .busy    (map_busy)
    );

    assign req_stall  = (state_reg != S_IDLE) || map_busy;
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // In the scan state the read data always belongs to the entry at cur_reg.
    assign cur_inc   = cur_reg + CUR_W'(1);
    assign cur_skip  = cur_reg + CUR_W'(map_rd_data);
    assign fb_inc    = fb_reg + FB_W'(BLOCK_BYTES);
    assign found_inc = found_reg + FOUND_W'(1);

    // A free address turns into a block number by a reciprocal multiply; the
    // product is registered and the quotient is taken in the next cycle.
    assign free_below_heap = 32'(req.release_address) < 32'(BLOCK_COUNT);
    assign free_offset     = req.release_address - ADDR_W'(BLOCK_COUNT);
    assign free_quot       = prod_reg[RECIP_SHIFT +: ADDR_W];

    assign grant_full = 32'(BLOCK_COUNT) + 32'(start_reg) * 32'(BLOCK_BYTES);

    // Writes to the map happen only in the commit and free states, where no
    // read is issued, and the next item's reads come in later cycles, so no
    // forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        fb_next        = fb_reg;
        bytes_next     = bytes_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        map_rd_en      = 1'b0;
        map_rd_addr    = '0;
        map_wr_en      = 1'b0;
        map_wr_addr    = '0;
        map_wr_data    = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            res_next   = '{STATUS_ZERO, '0, '0};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            bytes_next  = req.request_bytes;
                            cur_next    = '0;
                            start_next  = '0;
                            found_next  = '0;
                            fb_next     = '0;
                            map_rd_en   = 1'b1;
                            map_rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_below_heap)
                        begin
                            res_next   = '{STATUS_BAD_FREE, '0, '0};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            prod_next  = PROD_W'(free_offset) * PROD_W'(RECIP_M);
                            state_next = S_FREE;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (map_rd_data == '0)
                begin
                    // Free entry: the run grows by one block.
                    found_next = found_inc;
                    fb_next    = fb_inc;
                    cur_next   = cur_inc;
                    if (fb_inc >= FB_W'(bytes_reg))
                    begin
                        state_next = S_COMMIT;
                    end
                    else if (cur_inc >= CUR_W'(BLOCK_COUNT))
                    begin
                        res_next   = '{STATUS_NO_RUN, '0, '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        map_rd_en   = 1'b1;
                        map_rd_addr = cur_inc[BLK_W-1:0];
                    end
                end
                else
                begin
                    // Start of an allocation: jump over it and restart the run.
                    found_next = '0;
                    fb_next    = '0;
                    cur_next   = cur_skip;
                    if (cur_skip >= CUR_W'(BLOCK_COUNT))
                    begin
                        res_next   = '{STATUS_NO_RUN, '0, '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        start_next  = cur_skip[BLK_W-1:0];
                        map_rd_en   = 1'b1;
                        map_rd_addr = cur_skip[BLK_W-1:0];
                    end
                end
            end

            S_COMMIT:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = start_reg;
                map_wr_data = found_reg[MAP_W-1:0];
                res_next    = '{STATUS_OK, grant_full[ADDR_W-1:0], BLKNUM_W'(start_reg)};
                state_next  = S_RESP;
            end

            S_FREE:
            begin
                if (32'(free_quot) >= 32'(BLOCK_COUNT))
                begin
                    res_next = '{STATUS_BAD_FREE, '0, '0};
                end
                else
                begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = free_quot[BLK_W-1:0];
                    map_wr_data = '0;
                    res_next    = '{STATUS_OK, '0, BLKNUM_W'(free_quot)};
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        start_reg <= start_next;
        found_reg <= found_next;
        fb_reg    <= fb_next;
        bytes_reg <= bytes_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // The map's read and write ports are never both used by the control logic.
    assert property (@(posedge clk) disable iff (!rst_n)
        map_wr_en |-> !map_rd_en)
        else $error("block map read and write in the same cycle");

    // An accepted item always starts work.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg != S_IDLE)
        else $error("accepted item did not leave idle");

    // While scanning, the entry being examined lies inside the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cur_reg < CUR_W'(BLOCK_COUNT))
        else $error("scan position beyond the last block");

    // A commit follows a scan that found a nonempty run.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT |-> ($past(state_reg) == S_SCAN && found_reg != '0))
        else $error("commit without a completed scan");
`endif

endmodule
